>>> sv/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// shared types and constants of the metronome click synthesizer
// ----------------------------------------------------------------------------
package mcs_pkg;

	typedef struct packed {
		logic [63:0]        sample_position;
		logic               playing;
		logic signed [23:0] in_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] out_sample;
		logic signed [23:0] click_sample;
		logic [1:0]         tick_kind;
	} out_item_t;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SUB  = 2'd1;
	localparam logic [1:0] KIND_BEAT = 2'd2;
	localparam logic [1:0] KIND_BAR  = 2'd3;

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_PERIOD  = 2'd1;
	localparam logic [1:0] REG_BAR_NUM = 2'd2;
	localparam logic [1:0] REG_BAR_DEN = 2'd3;

	localparam int          CFG_W       = 20;
	localparam logic [24:0] ENV_ONE     = 25'd16777216;
	localparam logic [24:0] ENV_FLOOR   = 25'd1677;
	localparam int          DIV_STEPS   = 64;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic start;
		logic rd;
		logic mul1;
		logic mul2;
		logic finish;
	} mcs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic active;
	} mcs_stat_t;

	function automatic logic [12:0] gain_of(input logic [1:0] kind);
		logic [12:0] g;
		unique case (kind)
			KIND_BAR:  g = 13'd6554;
			KIND_BEAT: g = 13'd5243;
			default:   g = 13'd3932;
		endcase
		return g;
	endfunction

endpackage

>>> sv/mcs_ctrl.sv
// ----------------------------------------------------------------------------
// mcs_ctrl
// sequencer: serial division, tick start, one pass per voice, output slot
// ----------------------------------------------------------------------------
module mcs_ctrl #(
	parameter int VOICE_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  mcs_pkg::mcs_stat_t stat,
	output mcs_pkg::mcs_cmd_t  cmd,
	output logic [((VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1)-1:0] vidx
);
	import mcs_pkg::*;

	localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam logic [VW-1:0] VLAST = VW'(VOICE_COUNT - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHK   = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_START = 7'b0001000,
		ST_RD    = 7'b0010000,
		ST_MUL1  = 7'b0100000,
		ST_MUL2  = 7'b1000000
	} state_t;

	// the done step reuses idle encoding space through a flag
	state_t         state_q, state_d;
	logic           done_q, done_d;
	logic [5:0]     cnt_q, cnt_d;
	logic [VW-1:0]  vidx_q, vidx_d;
	logic           out_valid_q;
	logic           fire;

	assign in_stall  = (state_q != ST_IDLE) || done_q;
	assign out_valid = out_valid_q;
	assign vidx      = vidx_q;
	assign fire      = done_q && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		done_d  = done_q;
		cnt_d   = cnt_q;
		vidx_d  = vidx_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (done_q) begin
					if (fire) begin
						cmd.finish = 1'b1;
						done_d     = 1'b0;
					end
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHK;
				end
			end
			ST_CHK: begin
				cnt_d = '0;
				if (stat.active) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				vidx_d    = '0;
				state_d   = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				if (vidx_q == VLAST) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else begin
					vidx_d  = vidx_q + VW'(1);
					state_d = ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
				done_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			cnt_q       <= '0;
			vidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			cnt_q   <= cnt_d;
			vidx_q  <= vidx_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/mcs_datapath.sv
// ----------------------------------------------------------------------------
// mcs_datapath
// registers, restoring divider, sine rom, voice store and mixing multipliers
// ----------------------------------------------------------------------------
module mcs_datapath #(
	parameter int VOICE_COUNT      = 4,
	parameter int SAMPLE_RATE      = 48000,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [mcs_pkg::CFG_W-1:0]    cfg_wdata,
	input  mcs_pkg::in_item_t            in_data,
	output mcs_pkg::out_item_t           out_data,
	input  mcs_pkg::mcs_cmd_t            cmd,
	input  logic [((VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1)-1:0] vidx,
	output mcs_pkg::mcs_stat_t           stat
);
	import mcs_pkg::*;

	localparam int VW   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int IDXW = $clog2(SINE_TABLE_DEPTH);
	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
	localparam longint unsigned TAYLOR_DIV [8] = '{1, 6, 20, 42, 72, 110, 156, 210};

	function automatic logic signed [23:0] sine_entry(input longint unsigned idx);
		longint unsigned th, term, q;
		longint          acc;
		logic            neg;
		th  = (idx * TWO_PI_Q30) / SINE_TABLE_DEPTH;
		neg = 1'b0;
		if (th >= PI_Q30) begin
			th  = th - PI_Q30;
			neg = 1'b1;
		end
		if (th > HALF_PI_Q30) th = PI_Q30 - th;
		term = th;
		acc  = longint'(th);
		for (int k = 1; k <= 7; k++) begin
			term = (((term * th) >> 30) * th) >> 30;
			term = term / TAYLOR_DIV[k];
			if (k % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		q = (longint'(acc) + 64) >> 7;
		if (q > 64'd8388607) q = 64'd8388607;
		return neg ? -24'(q) : 24'(q);
	endfunction

	function automatic longint unsigned pow_q24(input longint unsigned b, input longint unsigned e);
		longint unsigned a, bb, n;
		a  = 64'd16777216;
		bb = b;
		n  = e;
		while (n != 0) begin
			if (n[0]) a = (a * bb) >> 24;
			bb = (bb * bb) >> 24;
			n  = n >> 1;
		end
		return a;
	endfunction

	function automatic logic [23:0] decay_for(input longint unsigned ms);
		longint unsigned n, lo, hi, mid;
		n  = (longint'(SAMPLE_RATE) * ms + 500) / 1000;
		lo = 0;
		hi = 64'd16777215;
		if (n < 1) n = 1;
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (pow_q24(mid, n) >= 64'd16777) hi = mid;
			else lo = mid + 1;
		end
		return 24'(lo);
	endfunction

	function automatic logic [31:0] inc_for(input longint unsigned f);
		return 32'(((f << 32) + longint'(SAMPLE_RATE / 2)) / SAMPLE_RATE);
	endfunction

	localparam logic [31:0] INC_BAR   = inc_for(2200);
	localparam logic [31:0] INC_BEAT  = inc_for(1700);
	localparam logic [31:0] INC_SUB   = inc_for(1200);
	localparam logic [23:0] DEC_BAR   = decay_for(24);
	localparam logic [23:0] DEC_BEAT  = decay_for(20);
	localparam logic [23:0] DEC_SUB   = decay_for(18);

	// configuration
	logic              enable_q;
	logic [19:0]       period_q;
	logic [7:0]        bar_num_q;
	logic [7:0]        bar_den_q;

	// item
	logic [63:0]        pos_q;
	logic               playing_q;
	logic signed [23:0] smp_q;
	logic [19:0]        rem_q;
	logic [11:0]        modm_q;
	logic [1:0]         tick_q;
	logic signed [27:0] acc_q;

	// voices
	logic              v_act_q   [VOICE_COUNT];
	logic [31:0]       v_phase_q [VOICE_COUNT];
	logic [24:0]       v_env_q   [VOICE_COUNT];
	logic [1:0]        v_kind_q  [VOICE_COUNT];
	logic [VW-1:0]     nv_q;

	// mixing
	logic signed [23:0] rom_q;
	logic [23:0]        prod_q;
	logic               neg_q;
	logic [24:0]        envd_q;

	logic signed [23:0] sine_rom [SINE_TABLE_DEPTH];
	for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
		assign sine_rom[gi] = sine_entry(longint'(gi));
	end

	// bar length on the 1/16 grid
	logic [7:0]  num_eff;
	logic [5:0]  den_eff;
	logic [2:0]  den_sh;
	logic [13:0] steps_raw;
	logic [11:0] steps;
	always_comb begin
		num_eff = (bar_num_q == 8'd0) ? 8'd4 : bar_num_q;
		unique case (bar_den_q)
			8'd1:    begin den_eff = 6'd1;  den_sh = 3'd1; end
			8'd2:    begin den_eff = 6'd2;  den_sh = 3'd2; end
			8'd8:    begin den_eff = 6'd8;  den_sh = 3'd4; end
			8'd16:   begin den_eff = 6'd16; den_sh = 3'd5; end
			8'd32:   begin den_eff = 6'd32; den_sh = 3'd6; end
			default: begin den_eff = 6'd4;  den_sh = 3'd3; end
		endcase
		steps_raw = (({6'd0, num_eff} << 5) + {8'd0, den_eff}) >> den_sh;
		steps     = (steps_raw == 14'd0) ? 12'd1 : steps_raw[11:0];
	end

	// one restoring divider step, quotient bit folded into the bar position
	logic [19:0] per;
	logic [20:0] rem_sh;
	logic        qbit;
	logic [19:0] rem_nx;
	logic [12:0] modm_sh;
	logic [11:0] modm_nx;
	always_comb begin
		per     = (period_q == 20'd0) ? 20'd1 : period_q;
		rem_sh  = {rem_q, pos_q[63]};
		qbit    = (rem_sh >= {1'b0, per});
		rem_nx  = qbit ? 20'(rem_sh - {1'b0, per}) : rem_sh[19:0];
		modm_sh = {modm_q, qbit};
		modm_nx = (modm_sh >= {1'b0, steps}) ? 12'(modm_sh - {1'b0, steps}) : modm_sh[11:0];
	end

	logic [1:0] new_kind;
	assign new_kind = (modm_q == 12'd0) ? KIND_BAR :
		(modm_q[1:0] == 2'd0) ? KIND_BEAT : KIND_SUB;

	// per-voice selects
	logic [1:0]  cur_kind;
	logic [31:0] cur_inc;
	logic [23:0] cur_dec;
	logic [IDXW+31:0] idx_prod;
	logic [IDXW-1:0]  rom_idx;
	logic [22:0]      mag;
	logic [47:0]      p1;
	logic [48:0]      pe;
	logic [36:0]      p2;
	logic [20:0]      contrib;
	always_comb begin
		cur_kind = v_kind_q[vidx];
		unique case (cur_kind)
			KIND_BAR:  begin cur_inc = INC_BAR;  cur_dec = DEC_BAR;  end
			KIND_BEAT: begin cur_inc = INC_BEAT; cur_dec = DEC_BEAT; end
			default:   begin cur_inc = INC_SUB;  cur_dec = DEC_SUB;  end
		endcase
		idx_prod = {{IDXW{1'b0}}, v_phase_q[vidx]} * (IDXW+32)'(SINE_TABLE_DEPTH);
		rom_idx  = idx_prod[IDXW+31:32];
		mag      = rom_q[23] ? 23'(-rom_q) : rom_q[22:0];
		p1       = {1'b0, mag} * {23'd0, v_env_q[vidx]};
		pe       = {24'd0, v_env_q[vidx]} * {25'd0, cur_dec};
		p2       = {13'd0, prod_q} * {24'd0, gain_of(cur_kind)};
		contrib  = p2[36:16];
	end

	// output saturation
	logic signed [23:0] click_sat;
	logic signed [24:0] sum25;
	logic signed [23:0] out_sat;
	always_comb begin
		if (acc_q > 28'sd8388607) click_sat = 24'sd8388607;
		else if (acc_q < -28'sd8388608) click_sat = -24'sd8388608;
		else click_sat = acc_q[23:0];
		sum25 = 25'(smp_q) + 25'(click_sat);
		if (sum25 > 25'sd8388607) out_sat = 24'sd8388607;
		else if (sum25 < -25'sd8388608) out_sat = -24'sd8388608;
		else out_sat = sum25[23:0];
	end

	assign stat.active = enable_q && playing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			period_q  <= 20'd24000;
			bar_num_q <= 8'd4;
			bar_den_q <= 8'd4;
			nv_q      <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				v_act_q[i]   <= 1'b0;
				v_phase_q[i] <= '0;
				v_env_q[i]   <= '0;
				v_kind_q[i]  <= KIND_NONE;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE: begin
						enable_q <= cfg_wdata[0];
						if (!cfg_wdata[0]) begin
							for (int i = 0; i < VOICE_COUNT; i++) begin
								v_act_q[i]   <= 1'b0;
								v_phase_q[i] <= '0;
								v_env_q[i]   <= '0;
								v_kind_q[i]  <= KIND_NONE;
							end
						end
					end
					REG_PERIOD:  period_q  <= cfg_wdata;
					REG_BAR_NUM: bar_num_q <= cfg_wdata[7:0];
					REG_BAR_DEN: bar_den_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (cmd.start && rem_q == 20'd0) begin
				v_act_q[nv_q]   <= 1'b1;
				v_phase_q[nv_q] <= '0;
				v_env_q[nv_q]   <= ENV_ONE;
				v_kind_q[nv_q]  <= new_kind;
				nv_q <= (nv_q == VW'(VOICE_COUNT - 1)) ? '0 : nv_q + VW'(1);
			end
			if (cmd.mul2 && v_act_q[vidx]) begin
				if (envd_q <= ENV_FLOOR) begin
					v_act_q[vidx]   <= 1'b0;
					v_phase_q[vidx] <= '0;
					v_env_q[vidx]   <= '0;
					v_kind_q[vidx]  <= KIND_NONE;
				end else begin
					v_phase_q[vidx] <= v_phase_q[vidx] + cur_inc;
					v_env_q[vidx]   <= envd_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q     <= in_data.sample_position;
			playing_q <= in_data.playing;
			smp_q     <= in_data.in_sample;
			rem_q     <= '0;
			modm_q    <= '0;
			tick_q    <= KIND_NONE;
			acc_q     <= '0;
		end
		if (cmd.div_step) begin
			pos_q  <= {pos_q[62:0], 1'b0};
			rem_q  <= rem_nx;
			modm_q <= modm_nx;
		end
		if (cmd.start && rem_q == 20'd0) begin
			tick_q <= new_kind;
		end
		if (cmd.rd) begin
			rom_q <= sine_rom[rom_idx];
		end
		if (cmd.mul1) begin
			prod_q <= p1[47:24];
			neg_q  <= rom_q[23];
			envd_q <= pe[48:24];
		end
		if (cmd.mul2 && v_act_q[vidx]) begin
			acc_q <= neg_q ? acc_q - 28'(contrib) : acc_q + 28'(contrib);
		end
		if (cmd.finish) begin
			out_data.out_sample   <= out_sat;
			out_data.click_sample <= click_sat;
			out_data.tick_kind    <= tick_q;
		end
	end

endmodule

>>> sv/metronome_click_synth.sv
// ----------------------------------------------------------------------------
// metronome_click_synth
// adds round-robin sine clicks at tick positions of the transport to audio
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  input   | in_valid, in_stall, in_data      | position, playing, sample
//  output  | out_valid, out_stall, out_data   | mixed sample, click, tick kind
//  config  | cfg_we, cfg_index, cfg_wdata     | register writes
//
// one item at a time. when disabled or not playing the item skips the
// division and the voice passes; otherwise the one-bit-per-cycle divider
// runs, then each voice takes a rom read and two multiply steps
// through the shared multipliers. the output register holds a result
// under stall while the next item is taken. no clearing pass after reset.
module metronome_click_synth #(
	parameter int VOICE_COUNT      = 4,
	parameter int SAMPLE_RATE      = 48000,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  mcs_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output mcs_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [mcs_pkg::CFG_W-1:0]  cfg_wdata
);
	import mcs_pkg::*;

	localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	mcs_cmd_t      cmd;
	mcs_stat_t     stat;
	logic [VW-1:0] vidx;

	mcs_ctrl #(
		.VOICE_COUNT(VOICE_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd),
		.vidx     (vidx)
	);

	mcs_datapath #(
		.VOICE_COUNT     (VOICE_COUNT),
		.SAMPLE_RATE     (SAMPLE_RATE),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.vidx     (vidx),
		.stat     (stat)
	);

endmodule
